>>> hdl/dgrc_pkg.sv
package dgrc_pkg;

	// map storage
	localparam int MAP_CELLS = 4096;
	localparam int ADDR_W    = $clog2(MAP_CELLS);
	localparam int MAX_STEPS = 128;
	localparam int STEP_W    = $clog2(MAX_STEPS + 1);

	// angle format
	localparam int ANGLE_STEPS = 4096;
	localparam int ANG_W       = $clog2(ANGLE_STEPS);
	localparam int QUARTER     = ANGLE_STEPS / 4;
	localparam int QUAD_W      = ANG_W - 2;
	localparam int FRAC_SH     = 16 - QUAD_W;

	// quarter wave polynomial, Q30
	localparam logic [31:0] K1 = 32'd1686629713;
	localparam logic [31:0] K3 = 32'd693598671;
	localparam logic [31:0] K5 = 32'd85569306;
	localparam logic [31:0] K7 = 32'd4858524;

	localparam logic [23:0] SAT24 = 24'hFFFFFF;
	localparam logic [21:0] MAX22 = 22'h3FFFFF;

	// reciprocal divider runs over all 33 dividend bits of 2^32
	localparam int DIV_BITS = 33;

	typedef enum logic [1:0] {
		CFG_MAP_WIDTH,
		CFG_MAP_HEIGHT,
		CFG_CENTER_OFFSET
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SIN,
		ST_DIV,
		ST_SIDE,
		ST_STEP,
		ST_LOOK,
		ST_FIN,
		ST_DONE
	} state_t;

endpackage

>>> hdl/dgrc_ram.sv
module dgrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end

endmodule

>>> hdl/dda_grid_ray_caster_top.sv
// Grid ray caster with a loadable tile map.
// Input channel (in_valid / in_stall): a word with mode 0 writes cell_value into
// the tile at cell_index and gives no result; a word with mode 1 casts one ray
// and gives exactly one result word on the output channel (out_valid /
// out_stall): length, corrected length, end point, struck side and no_hit.
// Configuration (cfg_we, cfg_index, cfg_data) sets map width, map height and
// the center offset; write it only while the block is idle.
// A ray runs through these steps in order: the sine polynomial on the shared
// 32x32 multiplier, the bit-serial reciprocal, the initial side distances,
// the grid walk of at most 128 steps, each with a registered tile memory read,
// and the finish. One ray is worked at a time; in_stall is high meanwhile.
// After reset the tile memory is cleared one cell a cycle, all 4096 cells, with
// in_stall high; config writes are taken during that time.
// The result sits in an output register; while out_stall is high it holds and
// the block still takes the next word, finishing a ray waits for the slot.
module dda_grid_ray_caster_top
	import dgrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [11:0] cell_index,
	input  logic [7:0]  cell_value,
	input  logic [21:0] player_x,
	input  logic [21:0] player_y,
	input  logic [11:0] player_angle,
	input  logic [11:0] ray_angle,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [23:0] ray_length,
	output logic [23:0] corrected_length,
	output logic [21:0] end_x,
	output logic [21:0] end_y,
	output logic        vertical_side,
	output logic        no_hit
);

	state_t state_q, state_d;

	logic [6:0]  width_q, height_q;
	logic [15:0] offset_q;
	logic [11:0] cnt_q;
	logic [1:0]  sel_q;
	logic        out_valid_q;

	logic [22:0] sx_q, sy_q;
	logic [ANG_W-1:0] pa_q, ra_q;
	logic [31:0] x2_q, t_q;
	logic signed [17:0] dx_q, dy_q, cr_q;
	logic [16:0] remx_q, remy_q;
	logic [DIV_BITS-1:0] qx_q, qy_q;
	logic [23:0] dlx_q, dly_q;
	logic [31:0] sdx_q, sdy_q, len_q;
	logic signed [8:0] tx_q, ty_q;
	logic [STEP_W-1:0] steps_q;
	logic        vert_q, hit_q;
	logic [23:0] corr_q;
	logic [21:0] ex_q, ey_q;

	logic [23:0] ray_length_q, corrected_length_q;
	logic [21:0] end_x_q, end_y_q;
	logic        vertical_side_q, no_hit_q;

	logic in_acc, out_free;
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// sine argument and quarter wave fraction
	logic [ANG_W-1:0] ang_sum, ang_cur;
	logic [1:0]  quad;
	logic [16:0] xfrac, xv;
	logic [31:0] xs;
	assign ang_sum = pa_q + ra_q;
	always_comb begin
		case (sel_q)
			2'd0:    ang_cur = ang_sum;
			2'd1:    ang_cur = ang_sum + ANG_W'(QUARTER);
			2'd2:    ang_cur = ra_q + ANG_W'(QUARTER);
			default: ang_cur = ang_sum;
		endcase
	end
	assign quad  = ang_cur[ANG_W-1 -: 2];
	assign xfrac = 17'({ang_cur[QUAD_W-1:0], {FRAC_SH{1'b0}}});
	assign xv    = quad[0] ? 17'd65536 - xfrac : xfrac;
	assign xs    = 32'({xv, 14'd0});

	// direction magnitudes
	logic [16:0] mx, my, mcr;
	assign mx  = dx_q[17] ? 17'(-dx_q) : dx_q[16:0];
	assign my  = dy_q[17] ? 17'(-dy_q) : dy_q[16:0];
	assign mcr = cr_q[17] ? 17'd0 : cr_q[16:0];

	// shared multiplier operand select
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SIN: begin
				case (cnt_q[2:0])
					3'd0:    begin mul_a = xs;   mul_b = xs; end
					3'd1:    begin mul_a = x2_q; mul_b = K7; end
					3'd4:    begin mul_a = xs;   mul_b = t_q; end
					default: begin mul_a = x2_q; mul_b = t_q; end
				endcase
			end
			ST_SIDE: begin
				if (cnt_q[0]) begin
					mul_a = 32'(dy_q[17] ? {1'b0, sy_q[15:0]} : 17'd65536 - sy_q[15:0]);
					mul_b = 32'(dly_q);
				end else begin
					mul_a = 32'(dx_q[17] ? {1'b0, sx_q[15:0]} : 17'd65536 - sx_q[15:0]);
					mul_b = 32'(dlx_q);
				end
			end
			ST_FIN: begin
				mul_a = len_q;
				case (cnt_q[1:0])
					2'd0:    mul_b = 32'(mcr);
					2'd1:    mul_b = 32'(mx);
					default: mul_b = 32'(my);
				endcase
			end
			default: ;
		endcase
	end
	assign prod = mul_a * mul_b;

	// polynomial step results
	logic [33:0] prod_hi, s_rnd;
	logic [19:0] s_val;
	logic [16:0] s_cap;
	logic signed [17:0] sin_res;
	logic [31:0] t_next;
	assign prod_hi = prod[63:30];
	assign s_rnd   = prod_hi + 34'd8192;
	assign s_val   = s_rnd[33:14];
	assign s_cap   = (s_val > 20'd65536) ? 17'd65536 : s_val[16:0];
	assign sin_res = quad[1] ? -$signed({1'b0, s_cap}) : $signed({1'b0, s_cap});
	always_comb begin
		case (cnt_q[2:0])
			3'd1:    t_next = K5 - prod_hi[31:0];
			3'd2:    t_next = K3 - prod_hi[31:0];
			default: t_next = K1 - prod_hi[31:0];
		endcase
	end

	// reciprocal digit step, both axes together
	logic        div_bit;
	logic [17:0] rx_sh, ry_sh;
	logic        gx, gy;
	logic [DIV_BITS-1:0] qx_n, qy_n;
	logic [16:0] remx_n, remy_n;
	assign div_bit = (cnt_q == 12'd0);
	assign rx_sh   = {remx_q, div_bit};
	assign ry_sh   = {remy_q, div_bit};
	assign gx      = rx_sh >= {1'b0, mx};
	assign gy      = ry_sh >= {1'b0, my};
	assign remx_n  = gx ? 17'(rx_sh - {1'b0, mx}) : rx_sh[16:0];
	assign remy_n  = gy ? 17'(ry_sh - {1'b0, my}) : ry_sh[16:0];
	assign qx_n    = {qx_q[DIV_BITS-2:0], gx};
	assign qy_n    = {qy_q[DIV_BITS-2:0], gy};

	// one grid step
	logic        go_x, off_map;
	logic signed [8:0] tx_n, ty_n;
	logic [13:0] idx;
	assign go_x = sdx_q < sdy_q;
	assign tx_n = go_x ? (dx_q[17] ? tx_q - 9'sd1 : tx_q + 9'sd1) : tx_q;
	assign ty_n = go_x ? ty_q : (dy_q[17] ? ty_q - 9'sd1 : ty_q + 9'sd1);
	assign idx  = 14'(ty_n[6:0] * width_q) + 14'(tx_n[6:0]);
	assign off_map = tx_n[8] || ty_n[8] || (tx_n[7:0] >= {1'b0, width_q})
		|| (ty_n[7:0] >= {1'b0, height_q}) || (32'(idx) >= MAP_CELLS);

	// end point for the axis in turn
	logic [32:0] emag;
	logic signed [34:0] e_val;
	logic [21:0] e_clamp;
	logic        e_neg;
	logic [22:0] e_start;
	assign emag    = prod[48:16];
	assign e_neg   = cnt_q[1] ? dy_q[17] : dx_q[17];
	assign e_start = cnt_q[1] ? sy_q : sx_q;
	assign e_val   = e_neg ? $signed(35'(e_start)) - $signed(35'(emag))
		: $signed(35'(e_start)) + $signed(35'(emag));
	assign e_clamp = e_val[34] ? 22'd0 : (e_val > $signed(35'(MAX22)) ? MAX22 : e_val[21:0]);

	// tile memory
	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [7:0]        ram_wdata, ram_rdata;
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = cell_index[ADDR_W-1:0];
		ram_wdata = cell_value;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = cnt_q[ADDR_W-1:0];
				ram_wdata = '0;
			end
			ST_IDLE: ram_we = in_acc && !mode;
			ST_STEP: ram_addr = idx[ADDR_W-1:0];
			default: ;
		endcase
	end

	dgrc_ram #(.WIDTH(8), .DEPTH(MAP_CELLS)) u_tile_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (cnt_q == 12'(MAP_CELLS - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (in_acc && mode) state_d = ST_SIN;
			ST_SIN:   if (cnt_q == 12'd4 && sel_q == 2'd2) state_d = ST_DIV;
			ST_DIV:   if (cnt_q == 12'(DIV_BITS - 1)) state_d = ST_SIDE;
			ST_SIDE:  if (cnt_q == 12'd1) state_d = ST_STEP;
			ST_STEP: begin
				if (steps_q == STEP_W'(MAX_STEPS) || off_map)
					state_d = ST_FIN;
				else
					state_d = ST_LOOK;
			end
			ST_LOOK:  state_d = (ram_rdata != 8'd0) ? ST_FIN : ST_STEP;
			ST_FIN:   if (cnt_q == 12'd2) state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			sel_q       <= '0;
			out_valid_q <= 1'b0;
			width_q     <= 7'd10;
			height_q    <= 7'd10;
			offset_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q)
				cnt_q <= '0;
			else if (state_q == ST_SIN && cnt_q == 12'd4)
				cnt_q <= '0;
			else
				cnt_q <= cnt_q + 12'd1;
			if (state_q == ST_IDLE)
				sel_q <= '0;
			else if (state_q == ST_SIN && cnt_q == 12'd4)
				sel_q <= sel_q + 2'd1;
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_MAP_WIDTH:     width_q  <= cfg_data[6:0];
					CFG_MAP_HEIGHT:    height_q <= cfg_data[6:0];
					CFG_CENTER_OFFSET: offset_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sx_q  <= 23'(player_x) + 23'(offset_q);
				sy_q  <= 23'(player_y) + 23'(offset_q);
				pa_q  <= player_angle[ANG_W-1:0];
				ra_q  <= ray_angle[ANG_W-1:0];
				hit_q <= 1'b0;
			end
			ST_SIN: begin
				if (cnt_q == 12'd0)
					x2_q <= prod_hi[31:0];
				else if (cnt_q == 12'd4) begin
					case (sel_q)
						2'd0:    dx_q <= sin_res;
						2'd1:    dy_q <= sin_res;
						default: cr_q <= sin_res;
					endcase
				end else
					t_q <= t_next;
				remx_q <= '0;
				remy_q <= '0;
				qx_q   <= '0;
				qy_q   <= '0;
			end
			ST_DIV: begin
				remx_q <= remx_n;
				remy_q <= remy_n;
				qx_q   <= qx_n;
				qy_q   <= qy_n;
				dlx_q  <= (mx == 17'd0 || qx_n[DIV_BITS-1:24] != '0) ? SAT24 : qx_n[23:0];
				dly_q  <= (my == 17'd0 || qy_n[DIV_BITS-1:24] != '0) ? SAT24 : qy_n[23:0];
			end
			ST_SIDE: begin
				if (cnt_q[0])
					sdy_q <= prod[47:16];
				else
					sdx_q <= prod[47:16];
				tx_q    <= $signed({2'b00, sx_q[22:16]});
				ty_q    <= $signed({2'b00, sy_q[22:16]});
				steps_q <= '0;
				len_q   <= '0;
			end
			ST_STEP: begin
				if (steps_q != STEP_W'(MAX_STEPS)) begin
					if (go_x) begin
						len_q <= sdx_q;
						sdx_q <= sdx_q + 32'(dlx_q);
					end else begin
						len_q <= sdy_q;
						sdy_q <= sdy_q + 32'(dly_q);
					end
					tx_q    <= tx_n;
					ty_q    <= ty_n;
					vert_q  <= go_x;
					steps_q <= steps_q + STEP_W'(1);
				end
			end
			ST_LOOK: hit_q <= ram_rdata != 8'd0;
			ST_FIN: begin
				case (cnt_q[1:0])
					2'd0:    corr_q <= (prod[63:40] != '0) ? SAT24 : prod[39:16];
					2'd1:    ex_q   <= e_clamp;
					default: ey_q   <= e_clamp;
				endcase
			end
			ST_DONE: begin
				if (out_free) begin
					ray_length_q       <= hit_q ? ((len_q[31:24] != '0) ? SAT24 : len_q[23:0]) : '0;
					corrected_length_q <= hit_q ? corr_q : '0;
					end_x_q            <= hit_q ? ex_q : '0;
					end_y_q            <= hit_q ? ey_q : '0;
					vertical_side_q    <= hit_q && vert_q;
					no_hit_q           <= !hit_q;
				end
			end
			default: ;
		endcase
	end

	assign in_stall         = state_q != ST_IDLE;
	assign out_valid        = out_valid_q;
	assign ray_length       = ray_length_q;
	assign corrected_length = corrected_length_q;
	assign end_x            = end_x_q;
	assign end_y            = end_y_q;
	assign vertical_side    = vertical_side_q;
	assign no_hit           = no_hit_q;

	// a new result only comes from the finishing state
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside finish");

	// a miss carries no length or end point
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && no_hit_q) |-> (ray_length_q == '0 && end_x_q == '0
			&& end_y_q == '0 && !vertical_side_q))
		else $error("miss with nonzero payload");

	// the walk never passes the step limit
	a_step_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP || state_q == ST_LOOK) |-> steps_q <= STEP_W'(MAX_STEPS))
		else $error("step counter past limit");

	// tile writes only while clearing or idle
	a_ram_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || state_q == ST_IDLE))
		else $error("tile write during a cast");

endmodule

>>> test/dda_grid_ray_caster_top_test.sv
`timescale 1ns / 100ps

module dda_grid_ray_caster_top_test;
	import dgrc_pkg::*;

	localparam longint LIMIT_CYCLES = 3000000;
	localparam int DRAIN_CYCLES = 400;

	// quarter wave constants, Q30
	localparam bit [63:0] C1 = 64'd1686629713;
	localparam bit [63:0] C3 = 64'd693598671;
	localparam bit [63:0] C5 = 64'd85569306;
	localparam bit [63:0] C7 = 64'd4858524;
	localparam longint FULL24 = 64'hFFFFFF;
	localparam longint FULL22 = 64'h3FFFFF;

	typedef struct packed {
		logic [23:0] len;
		logic [23:0] corr;
		logic [21:0] ex;
		logic [21:0] ey;
		logic        vside;
		logic        miss;
	} hit_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        mode = 1'b0;
	logic [11:0] cell_index = '0;
	logic [7:0]  cell_value = '0;
	logic [21:0] player_x = '0;
	logic [21:0] player_y = '0;
	logic [11:0] player_angle = '0;
	logic [11:0] ray_angle = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [23:0] ray_length;
	logic [23:0] corrected_length;
	logic [21:0] end_x;
	logic [21:0] end_y;
	logic        vertical_side;
	logic        no_hit;

	// predictor copy of the map and the registers
	logic [7:0] tiles [MAP_CELLS];
	int unsigned grid_w = 10;
	int unsigned grid_h = 10;
	int unsigned offset = 0;

	hit_t pending_hits [$];
	int errors = 0;
	longint cycles = 0;
	bit jitter = 1'b1;

	dda_grid_ray_caster_top dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// cycle counter and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		out_stall <= jitter && ($urandom_range(0, 99) < 12);
	end

	function automatic bit [63:0] quarter_sine(bit [63:0] x);
		bit [63:0] xs, x2, t, s;
		xs = x << 14;
		x2 = (xs * xs) >> 30;
		t = C7;
		t = C5 - ((x2 * t) >> 30);
		t = C3 - ((x2 * t) >> 30);
		t = C1 - ((x2 * t) >> 30);
		s = (((xs * t) >> 30) + 64'd8192) >> 14;
		return (s > 64'd65536) ? 64'd65536 : s;
	endfunction

	function automatic longint sine(bit [63:0] ang);
		bit [63:0] a, quad, x, v;
		a = ang % ANGLE_STEPS;
		quad = (a / QUARTER) & 3;
		x = ((a % QUARTER) << 16) / QUARTER;
		v = quad[0] ? quarter_sine(64'd65536 - x) : quarter_sine(x);
		return quad[1] ? -longint'(v) : longint'(v);
	endfunction

	function automatic longint step_len(longint d);
		longint m, r;
		m = (d < 0) ? -d : d;
		if (m == 0)
			return FULL24;
		r = (longint'(1) << 32) / m;
		return (r > FULL24) ? FULL24 : r;
	endfunction

	function automatic longint hit_coord(longint start, longint d, longint len);
		longint m, e;
		m = (((d < 0) ? -d : d) * len) >> 16;
		e = (d < 0) ? start - m : start + m;
		if (e < 0) e = 0;
		if (e > FULL22) e = FULL22;
		return e;
	endfunction

	// walk the grid from the start point until a wall, the edge or the step limit
	function automatic hit_t cast_ray(logic [21:0] px, logic [21:0] py,
			logic [11:0] pa, logic [11:0] ra);
		hit_t res;
		longint sx, sy, dx, dy, cr, tx, ty, stx, sty, dlx, dly, sdx, sdy, len, corr, idx;
		bit found, vert;
		found = 1'b0;
		vert = 1'b0;
		sx = longint'(px) + offset;
		sy = longint'(py) + offset;
		dx = sine(64'(pa) + 64'(ra));
		dy = sine(64'(pa) + 64'(ra) + QUARTER);
		cr = sine(64'(ra) + QUARTER);
		tx = sx >> 16;
		ty = sy >> 16;
		dlx = step_len(dx);
		dly = step_len(dy);
		stx = (dx < 0) ? -1 : 1;
		sty = (dy < 0) ? -1 : 1;
		sdx = (((dx < 0) ? (sx & 65535) : 65536 - (sx & 65535)) * dlx) >> 16;
		sdy = (((dy < 0) ? (sy & 65535) : 65536 - (sy & 65535)) * dly) >> 16;
		len = 0;
		for (int n = 0; n < MAX_STEPS; n++) begin
			if (sdx < sdy) begin
				len = sdx;
				sdx += dlx;
				tx += stx;
				vert = 1'b1;
			end else begin
				len = sdy;
				sdy += dly;
				ty += sty;
				vert = 1'b0;
			end
			if (tx < 0 || ty < 0 || tx >= grid_w || ty >= grid_h)
				break;
			idx = ty * grid_w + tx;
			if (idx >= MAP_CELLS)
				break;
			if (tiles[idx] != 0) begin
				found = 1'b1;
				break;
			end
		end
		res = '0;
		if (!found) begin
			res.miss = 1'b1;
			return res;
		end
		if (cr <= 0)
			corr = 0;
		else begin
			corr = (len * cr) >> 16;
			if (corr > FULL24) corr = FULL24;
		end
		res.len = 24'((len > FULL24) ? FULL24 : len);
		res.corr = 24'(corr);
		res.ex = 22'(hit_coord(sx, dx, len));
		res.ey = 22'(hit_coord(sy, dy, len));
		res.vside = vert;
		return res;
	endfunction

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t %s expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// compare each result word with the oldest predicted hit
	always @(posedge clk) begin
		hit_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_hits.size() == 0) begin
				$display("%0t unexpected result word, expected none, actual length %0h",
					$time, ray_length);
				errors++;
			end else begin
				want = pending_hits.pop_front();
				check_field("ray_length", want.len, ray_length);
				check_field("corrected_length", want.corr, corrected_length);
				check_field("end_x", want.ex, end_x);
				check_field("end_y", want.ey, end_y);
				check_field("vertical_side", want.vside, vertical_side);
				check_field("no_hit", want.miss, no_hit);
			end
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			CFG_MAP_WIDTH: grid_w = value & 16'h7F;
			CFG_MAP_HEIGHT: grid_h = value & 16'h7F;
			default: offset = value;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_map(int w, int h, int off);
		write_reg(CFG_MAP_WIDTH, 16'(w));
		write_reg(CFG_MAP_HEIGHT, 16'(h));
		write_reg(CFG_CENTER_OFFSET, 16'(off));
	endtask

	// present one word and hold it until it is taken; valid stays high afterwards
	task automatic send_word(logic m, logic [11:0] ci, logic [7:0] cv, logic [21:0] px,
			logic [21:0] py, logic [11:0] pa, logic [11:0] ra);
		if (jitter && $urandom_range(0, 99) < 12) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		cell_index <= ci;
		cell_value <= cv;
		player_x <= px;
		player_y <= py;
		player_angle <= pa;
		ray_angle <= ra;
		do @(posedge clk); while (in_stall);
		if (m)
			pending_hits.push_back(cast_ray(px, py, pa, ra));
		else
			tiles[ci] = cv;
	endtask

	task automatic put_tile(int idx, int v);
		send_word(1'b0, 12'(idx), 8'(v), 22'($urandom), 22'($urandom), 12'($urandom),
			12'($urandom));
	endtask

	task automatic shoot(int px, int py, int pa, int ra);
		send_word(1'b1, 12'($urandom), 8'($urandom), 22'(px), 22'(py), 12'(pa), 12'(ra));
	endtask

	// drop valid, wait for all results and let a trailing map write finish
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// reset map is empty: every ray leaves the grid
	task automatic test_empty_map();
		shoot(22'h050000, 22'h050000, 0, 0);
		shoot(22'h3FFFFF, 22'h3FFFFF, 4095, 4095);
		shoot(0, 0, 2048, 0);
		settle();
	endtask

	// walls around a center tile, cardinal directions and angle extremes
	task automatic test_walls();
		put_tile(5 * 10 + 8, 255);
		put_tile(5 * 10 + 2, 1);
		put_tile(8 * 10 + 5, 128);
		put_tile(2 * 10 + 5, 7);
		put_tile(0, 255);
		shoot(22'h058000, 22'h058000, 0, 0);
		shoot(22'h058000, 22'h058000, 1024, 0);
		shoot(22'h058000, 22'h058000, 2048, 0);
		shoot(22'h058000, 22'h058000, 3072, 0);
		shoot(22'h050000, 22'h05FFFF, 512, 4095);
		shoot(22'h058000, 22'h058000, 4095, 1024);
		shoot(22'h058000, 22'h058000, 0, 2048);
		shoot(22'h00C000, 22'h00C000, 2560, 0);
		settle();
		set_map(10, 10, 65535);
		shoot(22'h048000, 22'h048000, 1024, 3072);
		shoot(22'h040000, 22'h040000, 0, 1);
		put_tile(5 * 10 + 8, 0);
		shoot(22'h058000, 22'h058000, 1024, 0);
		settle();
	endtask

	// random map contents and rays under one register setting
	task automatic test_random_phase(int w, int h, int off, int count, bit calm);
		int cells, px, py;
		jitter = !calm;
		set_map(w, h, off);
		cells = w * h;
		if (cells == 0 || cells > MAP_CELLS) cells = MAP_CELLS;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 30) begin
				case ($urandom_range(0, 5))
					0: put_tile($urandom_range(0, MAP_CELLS - 1), $urandom_range(0, 255));
					1: put_tile($urandom_range(0, cells - 1), 0);
					default: put_tile($urandom_range(0, cells - 1), $urandom_range(1, 255));
				endcase
			end else begin
				if ($urandom_range(0, 9) == 0) begin
					px = $urandom_range(0, 22'h3FFFFF);
					py = $urandom_range(0, 22'h3FFFFF);
				end else begin
					px = ($urandom_range(0, (w > 0 ? w : 1) - 1) << 16) | $urandom_range(0, 65535);
					py = ($urandom_range(0, (h > 0 ? h : 1) - 1) << 16) | $urandom_range(0, 65535);
				end
				shoot(px & 22'h3FFFFF, py & 22'h3FFFFF, $urandom_range(0, 4095),
					$urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) : $urandom_range(3584, 4607) % 4096);
			end
		end
		settle();
		jitter = 1'b1;
	endtask

	initial begin
		foreach (tiles[i])
			tiles[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_map();
		test_walls();
		test_random_phase(10, 10, 0, 120, 1'b0);
		test_random_phase(64, 64, 65535, 100, 1'b0);
		test_random_phase(1, 1, 0, 25, 1'b0);
		test_random_phase(0, 10, 1234, 20, 1'b0);
		test_random_phase(127, 127, 32768, 80, 1'b0);
		test_random_phase(16, 8, $urandom_range(0, 65535), 120, 1'b1);
		test_random_phase($urandom_range(2, 64), $urandom_range(2, 64),
			$urandom_range(0, 65535), 160, 1'b0);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
